FILE: hdl/bdcs_pkg.sv
// ----------------------------------------------------------------------------
// bdcs_pkg
// Shared constants and types for the class filtered best detection selector.
// ----------------------------------------------------------------------------
package bdcs_pkg;

    localparam int NUM_SLOTS   = 128;
    localparam int MAX_MATCHES = 16;

    localparam int SLOT_W  = $clog2(NUM_SLOTS);
    localparam int TAKEN_W = $clog2(MAX_MATCHES + 1);

    localparam int IDX_W   = 7;
    localparam int CLASS_W = 8;
    localparam int SCORE_W = 16;
    localparam int COORD_W = 16;
    localparam int SIZE_W  = 12;
    localparam int META_W  = CLASS_W + SCORE_W;
    localparam int BOX_W   = 4 * COORD_W;
    localparam int PROD_W  = SIZE_W + COORD_W + 1;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    localparam logic [SIZE_W-1:0] IMAGE_WIDTH_RST  = 12'd640;
    localparam logic [SIZE_W-1:0] IMAGE_HEIGHT_RST = 12'd480;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic [SIZE_W-1:0]  size;
        logic [COORD_W:0]   sum;
    } t_mul_req;

endpackage

FILE: hdl/bdcs_ram.sv
// ----------------------------------------------------------------------------
// bdcs_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module bdcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/bdcs_mul.sv
// ----------------------------------------------------------------------------
// bdcs_mul
// Shared centre multiplier: image size times edge sum, scaled down by 2^17.
// ----------------------------------------------------------------------------
module bdcs_mul (
    input  logic                       i_clk,
    input  bdcs_pkg::t_mul_req         i_req,
    output logic [bdcs_pkg::SIZE_W-1:0] o_center
);
    import bdcs_pkg::*;

    logic [PROD_W-1:0] prod;
    logic [SIZE_W-1:0] r_center;

    assign prod = PROD_W'(i_req.size) * PROD_W'(i_req.sum);

    always_ff @(posedge i_clk) begin
        r_center <= prod[PROD_W-1 -: SIZE_W];
    end

    assign o_center = r_center;

endmodule

FILE: hdl/bdcs_ctrl.sv
// ----------------------------------------------------------------------------
// bdcs_ctrl
// Detection table, scan sequencer and best score comparator.
// ----------------------------------------------------------------------------
module bdcs_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic                             i_kind,
    input  logic [bdcs_pkg::IDX_W-1:0]       i_slot_index,
    input  logic [bdcs_pkg::CLASS_W-1:0]     i_class_id,
    input  logic [bdcs_pkg::SCORE_W-1:0]     i_score,
    input  logic [bdcs_pkg::COORD_W-1:0]     i_box_ymin,
    input  logic [bdcs_pkg::COORD_W-1:0]     i_box_xmin,
    input  logic [bdcs_pkg::COORD_W-1:0]     i_box_ymax,
    input  logic [bdcs_pkg::COORD_W-1:0]     i_box_xmax,
    input  logic [bdcs_pkg::SIZE_W-1:0]      i_image_width,
    input  logic [bdcs_pkg::SIZE_W-1:0]      i_image_height,
    output bdcs_pkg::t_mul_req               o_mul_req,
    input  logic [bdcs_pkg::SIZE_W-1:0]      i_mul_center,
    output logic                             o_busy,
    output logic                             o_done,
    output logic                             o_found,
    output logic [bdcs_pkg::IDX_W-1:0]       o_best_slot,
    output logic [bdcs_pkg::COORD_W-1:0]     o_out_ymin,
    output logic [bdcs_pkg::COORD_W-1:0]     o_out_xmin,
    output logic [bdcs_pkg::COORD_W-1:0]     o_out_ymax,
    output logic [bdcs_pkg::COORD_W-1:0]     o_out_xmax,
    output logic [bdcs_pkg::SIZE_W-1:0]      o_center_x,
    output logic [bdcs_pkg::SIZE_W-1:0]      o_center_y
);
    import bdcs_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_BOX  = 3'd2;
    localparam logic [2:0] S_MULX = 3'd3;
    localparam logic [2:0] S_MULY = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0]           r_state;
    logic [2:0]           n_state;
    logic [NUM_SLOTS-1:0] r_valid;
    logic [SLOT_W-1:0]    r_addr;
    logic                 r_issuing;
    logic                 r_pend;
    logic                 r_pend_valid;
    logic [SLOT_W-1:0]    r_pend_addr;
    logic [CLASS_W-1:0]   r_cls;
    logic [TAKEN_W-1:0]   r_taken;
    logic                 r_have;
    logic [SLOT_W-1:0]    r_best;
    logic [SCORE_W-1:0]   r_best_score;
    logic [BOX_W-1:0]     r_box;
    logic [SIZE_W-1:0]    r_cx;
    logic                 r_done;
    logic                 r_found;
    logic [IDX_W-1:0]     r_best_slot;
    logic [COORD_W-1:0]   r_ymin;
    logic [COORD_W-1:0]   r_xmin;
    logic [COORD_W-1:0]   r_ymax;
    logic [COORD_W-1:0]   r_xmax;
    logic [SIZE_W-1:0]    r_center_x;
    logic [SIZE_W-1:0]    r_center_y;

    logic                 accept;
    logic                 write_go;
    logic [SLOT_W-1:0]    waddr;
    logic [META_W-1:0]    meta_rdata;
    logic [BOX_W-1:0]     box_rdata;
    logic [CLASS_W-1:0]   meta_class;
    logic [SCORE_W-1:0]   meta_score;
    logic                 hit;
    logic                 take_new;
    logic                 last_addr;

    assign accept    = (r_state == S_IDLE) && i_start;
    assign write_go  = accept && (i_kind == KIND_WRITE) && (32'(i_slot_index) < NUM_SLOTS);
    assign waddr     = SLOT_W'(i_slot_index);
    assign last_addr = (r_addr == SLOT_W'(NUM_SLOTS - 1));

    bdcs_ram #(
        .WIDTH (META_W),
        .DEPTH (NUM_SLOTS)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (write_go),
        .i_waddr (waddr),
        .i_wdata ({i_class_id, i_score}),
        .i_raddr (r_addr),
        .o_rdata (meta_rdata)
    );

    bdcs_ram #(
        .WIDTH (BOX_W),
        .DEPTH (NUM_SLOTS)
    ) u_box_ram (
        .i_clk   (i_clk),
        .i_we    (write_go),
        .i_waddr (waddr),
        .i_wdata ({i_box_xmax, i_box_ymax, i_box_xmin, i_box_ymin}),
        .i_raddr (r_best),
        .o_rdata (box_rdata)
    );

    assign meta_class = meta_rdata[META_W-1 -: CLASS_W];
    assign meta_score = meta_rdata[SCORE_W-1:0];

    assign hit      = r_pend && r_pend_valid && (meta_class == r_cls)
                      && (r_taken < TAKEN_W'(MAX_MATCHES));
    assign take_new = hit && (!r_have || (meta_score > r_best_score));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_kind == KIND_QUERY)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!r_issuing && !r_pend) begin
                    n_state = S_BOX;
                end
            end
            S_BOX:  n_state = S_MULX;
            S_MULX: n_state = S_MULY;
            S_MULY: n_state = S_FIN;
            S_FIN:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_mul_req.size = i_image_width;
        o_mul_req.sum  = (COORD_W + 1)'(box_rdata[31:16]) + (COORD_W + 1)'(box_rdata[63:48]);
        if (r_state != S_MULX) begin
            o_mul_req.size = i_image_height;
            o_mul_req.sum  = (COORD_W + 1)'(r_box[15:0]) + (COORD_W + 1)'(r_box[47:32]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_addr    <= '0;
            r_issuing <= 1'b0;
            r_pend    <= 1'b0;
            r_taken   <= '0;
            r_have    <= 1'b0;
            r_best    <= '0;
            r_done    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_FIN);
            if (write_go) begin
                r_valid[waddr] <= 1'b1;
            end
            if (accept && (i_kind == KIND_QUERY)) begin
                r_addr    <= '0;
                r_issuing <= 1'b1;
                r_pend    <= 1'b0;
                r_taken   <= '0;
                r_have    <= 1'b0;
                r_best    <= '0;
            end else if (r_state == S_SCAN) begin
                r_pend <= r_issuing;
                if (r_issuing) begin
                    if (last_addr) begin
                        r_issuing <= 1'b0;
                    end else begin
                        r_addr <= r_addr + SLOT_W'(1);
                    end
                end
                if (hit) begin
                    r_taken <= r_taken + TAKEN_W'(1);
                end
                if (take_new) begin
                    r_have <= 1'b1;
                    r_best <= r_pend_addr;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cls <= i_class_id;
        end
        r_pend_valid <= r_valid[r_addr];
        r_pend_addr  <= r_addr;
        if (take_new) begin
            r_best_score <= meta_score;
        end
        if (r_state == S_MULX) begin
            r_box <= box_rdata;
        end
        if (r_state == S_MULY) begin
            r_cx <= i_mul_center;
        end
        if (r_state == S_FIN) begin
            r_found     <= r_have;
            r_best_slot <= r_have ? IDX_W'(r_best) : '0;
            r_ymin      <= r_have ? r_box[15:0]  : '0;
            r_xmin      <= r_have ? r_box[31:16] : '0;
            r_ymax      <= r_have ? r_box[47:32] : '0;
            r_xmax      <= r_have ? r_box[63:48] : '0;
            r_center_x  <= r_have ? r_cx : '0;
            r_center_y  <= r_have ? i_mul_center : '0;
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_done      = r_done;
    assign o_found     = r_found;
    assign o_best_slot = r_best_slot;
    assign o_out_ymin  = r_ymin;
    assign o_out_xmin  = r_xmin;
    assign o_out_ymax  = r_ymax;
    assign o_out_xmax  = r_xmax;
    assign o_center_x  = r_center_x;
    assign o_center_y  = r_center_y;

endmodule

FILE: hdl/best_detection_of_class_select_top.sv
// ----------------------------------------------------------------------------
// best_detection_of_class_select_top
// Detection table with a class filtered best score query.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge where i_start is high and o_busy is low.
// With i_kind low the request writes one detection slot at that edge; o_busy
// stays low and no result follows.
// With i_kind high the request queries i_class_id. The slot table sits in a
// RAM and is scanned one slot per cycle; the first matching slots, up to the
// match limit, compete on score and the earliest slot wins a tie. The box of
// the winner is then read back and one shared multiplier forms the pixel
// centre in x and then in y.
// A query's result is shown for exactly one cycle with o_done high; o_busy
// falls in that same cycle, and the block takes no new request before then.
// The receiver cannot stall: o_done is a strobe.
// The image size registers are written through i_cfg_we, i_cfg_idx and
// i_cfg_wdata only while the block is idle; the user must keep to this, the block does not enforce it.
// Reset clears every slot's valid bit and restores a 640 by 480 image size.
// ----------------------------------------------------------------------------
module best_detection_of_class_select_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    output logic                             o_busy,
    input  logic                             i_kind,
    input  logic [bdcs_pkg::IDX_W-1:0]       i_slot_index,
    input  logic [bdcs_pkg::CLASS_W-1:0]     i_class_id,
    input  logic [bdcs_pkg::SCORE_W-1:0]     i_score,
    input  logic [bdcs_pkg::COORD_W-1:0]     i_box_ymin,
    input  logic [bdcs_pkg::COORD_W-1:0]     i_box_xmin,
    input  logic [bdcs_pkg::COORD_W-1:0]     i_box_ymax,
    input  logic [bdcs_pkg::COORD_W-1:0]     i_box_xmax,
    input  logic                             i_cfg_we,
    input  logic [bdcs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bdcs_pkg::SIZE_W-1:0]      i_cfg_wdata,
    output logic                             o_done,
    output logic                             o_found,
    output logic [bdcs_pkg::IDX_W-1:0]       o_best_slot,
    output logic [bdcs_pkg::COORD_W-1:0]     o_out_ymin,
    output logic [bdcs_pkg::COORD_W-1:0]     o_out_xmin,
    output logic [bdcs_pkg::COORD_W-1:0]     o_out_ymax,
    output logic [bdcs_pkg::COORD_W-1:0]     o_out_xmax,
    output logic [bdcs_pkg::SIZE_W-1:0]      o_center_x,
    output logic [bdcs_pkg::SIZE_W-1:0]      o_center_y
);
    import bdcs_pkg::*;

    logic [SIZE_W-1:0] r_image_width;
    logic [SIZE_W-1:0] r_image_height;
    t_mul_req          mul_req;
    logic [SIZE_W-1:0] mul_center;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= IMAGE_WIDTH_RST;
            r_image_height <= IMAGE_HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_wdata;
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    bdcs_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .i_kind         (i_kind),
        .i_slot_index   (i_slot_index),
        .i_class_id     (i_class_id),
        .i_score        (i_score),
        .i_box_ymin     (i_box_ymin),
        .i_box_xmin     (i_box_xmin),
        .i_box_ymax     (i_box_ymax),
        .i_box_xmax     (i_box_xmax),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .o_mul_req      (mul_req),
        .i_mul_center   (mul_center),
        .o_busy         (o_busy),
        .o_done         (o_done),
        .o_found        (o_found),
        .o_best_slot    (o_best_slot),
        .o_out_ymin     (o_out_ymin),
        .o_out_xmin     (o_out_xmin),
        .o_out_ymax     (o_out_ymax),
        .o_out_xmax     (o_out_xmax),
        .o_center_x     (o_center_x),
        .o_center_y     (o_center_y)
    );

    bdcs_mul u_mul (
        .i_clk    (i_clk),
        .i_req    (mul_req),
        .o_center (mul_center)
    );

endmodule
